[hw/rtl/rth_pkg.sv]
// Shared types, widths and helpers for the RGB to HSL converter.
package rth_pkg;

  localparam int ChanW  = 8;
  localparam int SumW   = 9;
  localparam int OutW   = 16;
  // Restoring divider: quotient bits produced, one per cell.
  localparam int QuoW   = 17;
  // Dividend numerator width: num * 65536 + 3c < 6c * 65536 + 3c fits in 28 bits.
  localparam int HNumW  = 28;
  localparam int HDenW  = 11;
  // Saturation: c * 65535 + d/2 fits in 24 bits; divisor d up to 255.
  localparam int SNumW  = 24;
  localparam int SDenW  = 9;

  // Hue and saturation divisions in flight: remainder, divisor and collected quotient bits, plus the sum.
  typedef struct packed {
    logic [HNumW-1:0] h_rem;
    logic [HDenW-1:0] h_den;
    logic [QuoW-1:0]  h_quo;
    logic             h_zero;
    logic [SNumW-1:0] s_rem;
    logic [SDenW-1:0] s_den;
    logic [QuoW-1:0]  s_quo;
    logic             s_zero;
    logic [SumW-1:0]  sum;
  } rth_cell_t;

endpackage

[hw/rtl/rgb_to_hsl_converter.sv]
// Top level of the RGB to HSL converter: front stage, divider cell chain, output.
// Fully pipelined: one pixel per clock while the output is not stalled. There are 19
// register stages (one front stage, 17 restoring-divider cells that each settle one
// quotient bit, one output register); the front stage loads at the accepting edge,
// and out_valid rises when the result reaches the output register. The pipeline advances
// whenever the output register is empty or being read, so ready drops only
// while a result waits downstream.
module rgb_to_hsl_converter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rth_pkg::ChanW-1:0]  red,
  input  logic [rth_pkg::ChanW-1:0]  green,
  input  logic [rth_pkg::ChanW-1:0]  blue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rth_pkg::OutW-1:0]   hue_turn,
  output logic [rth_pkg::OutW-1:0]   saturation_level,
  output logic [rth_pkg::SumW-1:0]   lightness_sum
);
  import rth_pkg::*;

  localparam int Stages = QuoW + 2;

  logic              adv;
  logic [Stages-2:0] vld;
  rth_cell_t         chain [QuoW+1];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[Stages-3:0], in_valid};
      out_valid <= vld[Stages-2];
    end
  end

  rth_front u_front (
    .clk(clk), .en(adv), .red(red), .green(green), .blue(blue),
    .cell_out(chain[0])
  );

  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    rth_div_cell #(.Bit(QuoW - 1 - i)) u_cell (
      .clk(clk), .en(adv), .cell_in(chain[i]), .cell_out(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (chain[QuoW].h_zero) begin
        hue_turn <= '0;
      end else if (chain[QuoW].h_quo[QuoW-1]) begin
        hue_turn <= '1;
      end else begin
        hue_turn <= chain[QuoW].h_quo[OutW-1:0];
      end
      if (chain[QuoW].s_zero) begin
        saturation_level <= '0;
      end else if (chain[QuoW].s_quo[QuoW-1]) begin
        saturation_level <= '1;
      end else begin
        saturation_level <= chain[QuoW].s_quo[OutW-1:0];
      end
      lightness_sum <= chain[QuoW].sum;
    end
  end

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue_turn) && $stable(lightness_sum))
    else $error("result changed while stalled");
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stage");
  a_light_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lightness_sum <= SumW'(510))
    else $error("lightness sum out of range");
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturation_level == '0 && lightness_sum != '0
      && lightness_sum != SumW'(510) |-> hue_turn == '0)
    else $error("grey pixel with nonzero hue");
`endif

endmodule

[hw/rtl/rth_front.sv]
// Front stage: max, min, chroma, hue numerator and saturation divisor per pixel.
module rth_front (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rth_pkg::ChanW-1:0] red,
  input  logic [rth_pkg::ChanW-1:0] green,
  input  logic [rth_pkg::ChanW-1:0] blue,
  output rth_pkg::rth_cell_t        cell_out
);
  import rth_pkg::*;

  logic [ChanW-1:0] mx, mn, c;
  logic [SumW-1:0]  s, d;
  logic [HDenW-1:0] num;
  rth_cell_t        cell_next;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    c = mx - mn;
    s = {1'b0, mx} + {1'b0, mn};
    if (mx == red) begin
      num = (blue > green) ? (HDenW'(6) * HDenW'(c) + HDenW'(green) - HDenW'(blue))
                           : (HDenW'(green) - HDenW'(blue));
    end else if (mx == green) begin
      num = HDenW'(2) * HDenW'(c) + HDenW'(blue) - HDenW'(red);
    end else begin
      num = HDenW'(4) * HDenW'(c) + HDenW'(red) - HDenW'(green);
    end
    d = (s > SumW'(255)) ? (SumW'(510) - s) : s;
    cell_next.h_rem  = HNumW'({num, 16'h0000}) + HNumW'(HDenW'(3) * HDenW'(c));
    cell_next.h_den  = HDenW'(6) * HDenW'(c);
    cell_next.h_quo  = '0;
    cell_next.h_zero = (c == '0);
    cell_next.s_rem  = ({c, 16'h0000} - SNumW'(c)) + SNumW'(d[SumW-1:1]);
    cell_next.s_den  = d;
    cell_next.s_quo  = '0;
    cell_next.s_zero = (d == '0);
    cell_next.sum    = s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

[hw/rtl/rth_div_cell.sv]
// One restoring-division cell: settles one quotient bit of hue and saturation.
module rth_div_cell #(
  parameter int Bit = 0
) (
  input  logic               clk,
  input  logic               en,
  input  rth_pkg::rth_cell_t cell_in,
  output rth_pkg::rth_cell_t cell_out
);
  import rth_pkg::*;

  localparam int HExtW = HNumW + Bit + 1;
  localparam int SExtW = SNumW + Bit + 1;

  logic [HExtW-1:0] h_trial;
  logic [SExtW-1:0] s_trial;
  rth_cell_t        cell_next;

  always_comb begin
    cell_next = cell_in;
    h_trial = HExtW'(cell_in.h_den) << Bit;
    s_trial = SExtW'(cell_in.s_den) << Bit;
    if (HExtW'(cell_in.h_rem) >= h_trial) begin
      cell_next.h_rem = cell_in.h_rem - HNumW'(h_trial);
      cell_next.h_quo[Bit] = 1'b1;
    end
    if (SExtW'(cell_in.s_rem) >= s_trial) begin
      cell_next.s_rem = cell_in.s_rem - SNumW'(s_trial);
      cell_next.s_quo[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

[sim/tb_rgb_to_hsl_converter.sv]
// Testbench for the RGB to HSL converter: directed and random pixels checked against a predictor.
module tb_rgb_to_hsl_converter;
  import rth_pkg::*;

  typedef struct {
    logic [OutW-1:0] hue;
    logic [OutW-1:0] sat;
    logic [SumW-1:0] sum;
  } hsl_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ChanW-1:0] red = '0, green = '0, blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OutW-1:0] hue_turn, saturation_level;
  logic [SumW-1:0] lightness_sum;

  hsl_t expected_hsl[$];
  int errors = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int cycle = 0;
  int stall_mode = 0;
  localparam int CycleLimit = 400000;

  rgb_to_hsl_converter dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("timeout after %0d cycles", cycle);
      $display("tb_rgb_to_hsl_converter: FAIL");
      $finish;
    end
  end

  function automatic hsl_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsl_t res;
    int unsigned mx, mn, c, s, d, num, h, sat;
    mx = 32'(r); mn = 32'(r);
    if (g > mx) mx = 32'(g);
    if (b > mx) mx = 32'(b);
    if (g < mn) mn = 32'(g);
    if (b < mn) mn = 32'(b);
    c = mx - mn;
    s = mx + mn;
    h = 0;
    if (c != 0) begin
      if (mx == r) num = (b > g) ? 6 * c + 32'(g) - 32'(b) : 32'(g) - 32'(b);
      else if (mx == g) num = 2 * c + 32'(b) - 32'(r);
      else num = 4 * c + 32'(r) - 32'(g);
      h = (num * 65536 + 3 * c) / (6 * c);
      if (h > 65535) h = 65535;
    end
    d = (s > 255) ? 510 - s : s;
    sat = 0;
    if (d != 0) begin
      sat = (c * 65535 + d / 2) / d;
      if (sat > 65535) sat = 65535;
    end
    res.hue = h[15:0];
    res.sat = sat[15:0];
    res.sum = s[8:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Sends one pixel; valid stays high across back-to-back transactions.
  // When valid drops, the bus idles with valid low before the next transaction.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit keep_valid);
    in_valid <= 1'b1;
    red <= r; green <= g; blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_hsl.push_back(convert_pixel(r, g, b));
    pixels_sent++;
    if (!keep_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (cycle % 7 < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    hsl_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_hsl.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_hsl.pop_front();
        if (hue_turn !== want.hue)
          report_mismatch("hue_turn", int'(hue_turn), int'(want.hue));
        if (saturation_level !== want.sat)
          report_mismatch("saturation_level", int'(saturation_level), int'(want.sat));
        if (lightness_sum !== want.sum)
          report_mismatch("lightness_sum", int'(lightness_sum), int'(want.sum));
      end
    end
  end

  task automatic test_directed();
    logic [7:0] px[22][3] = '{
      '{0, 0, 0}, '{255, 255, 255}, '{128, 128, 128}, '{255, 0, 0}, '{0, 255, 0},
      '{0, 0, 255}, '{255, 255, 0}, '{0, 255, 255}, '{255, 0, 255}, '{255, 255, 254},
      '{200, 200, 10}, '{10, 200, 200}, '{255, 0, 1}, '{255, 0, 255}, '{1, 0, 0},
      '{254, 255, 255}, '{170, 85, 85}, '{85, 170, 85}, '{85, 85, 170}, '{255, 1, 0},
      '{127, 128, 0}, '{0, 1, 254}};
    for (int i = 0; i < 22; i++) send_pixel(px[i][0], px[i][1], px[i][2], i != 21);
  endtask

  task automatic test_random(int count);
    int burst;
    int n;
    logic [7:0] r, g, b;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < count; k++) begin
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        // Some pixels near grey or with ties, where the sector logic is touchiest.
        if ($urandom_range(0, 5) == 0) g = 8'(32'(r) + $urandom_range(0, 2) - 1);
        if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? r : g;
        send_pixel(r, g, b, (k != burst - 1) && (n != count - 1));
        n++;
      end
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    int wait_cycles;
    wait_cycles = 0;
    while (expected_hsl.size() != 0) @(posedge clk);
    while (wait_cycles < 40) begin
      @(posedge clk);
      wait_cycles++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    stall_mode = 0;
    test_random(450);
    stall_mode = 1;
    test_random(500);
    stall_mode = 2;
    test_random(500);
    drain();
    $display("converted %0d pixels, %0d results checked, %0d mismatches",
             pixels_sent, results_seen, errors);
    $display("covered greys, primaries, ties for maximum, black and white, random bursts");
    if (errors == 0 && expected_hsl.size() == 0) begin
      $display("tb_rgb_to_hsl_converter: PASS");
    end else begin
      $display("tb_rgb_to_hsl_converter: FAIL");
    end
    $finish;
  end
endmodule

[rgb_to_hsl_converter.f]
hw/rtl/rth_pkg.sv
hw/rtl/rth_front.sv
hw/rtl/rth_div_cell.sv
hw/rtl/rgb_to_hsl_converter.sv
sim/tb_rgb_to_hsl_converter.sv
